// ===== rtl/core/plsq_pkg.sv =====
package plsq_pkg;

  localparam int CFG_IDX_BITS = 2;
  localparam int THICK_BITS   = 12;
  localparam int COLOR_BITS   = 32;
  localparam int Q_BITS       = 12;
  localparam int OFS_BITS     = Q_BITS + 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_THICKNESS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLOSED    = 2'd2;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_START,
    T_WAIT,
    T_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    A_IDLE,
    A_NORM,
    A_SQA,
    A_SQC,
    A_SQRT,
    A_MULX,
    A_DIVX,
    A_MULY,
    A_DIVY,
    A_DONE
  } arith_state_t;

  typedef struct packed {
    logic              done;
    logic [Q_BITS-1:0] qx;
    logic [Q_BITS-1:0] qy;
  } arith_rsp_t;

endpackage

// ===== rtl/core/plsq_arith.sv =====
module plsq_arith #(
  parameter int MAG_BITS = 21
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [MAG_BITS-1:0]               mag_a,
  input  logic [MAG_BITS-1:0]               mag_c,
  input  logic [plsq_pkg::THICK_BITS-1:0]   thickness,
  output plsq_pkg::arith_rsp_t              rsp
);
  import plsq_pkg::*;

  localparam int NW = (MAG_BITS > 31) ? MAG_BITS : 31;

  arith_state_t      st_r, st_nxt;
  logic [NW-1:0]     na_r, nc_r, mx;
  logic [61:0]       s_r, r_r, bit_r;
  logic [43:0]       num_r, trial;
  logic [Q_BITS-1:0] q_r, qx_r, qy_r, q_new;
  logic [4:0]        cnt_r;
  logic [29:0]       mul_a, mul_b;
  logic [59:0]       prod;
  logic [61:0]       sub_a, sub_b;
  logic [62:0]       diff;
  logic              ge;

  assign mx    = (na_r > nc_r) ? na_r : nc_r;
  assign trial = 44'({r_r[30:0], 1'b0}) << cnt_r[3:0];

  // The single multiplier serves both squares and both thickness products.
  always_comb begin
    unique case (st_r)
      A_SQA:   begin mul_a = na_r[29:0]; mul_b = na_r[29:0]; end
      A_SQC:   begin mul_a = nc_r[29:0]; mul_b = nc_r[29:0]; end
      A_MULX:  begin mul_a = na_r[29:0]; mul_b = 30'(thickness); end
      A_MULY:  begin mul_a = nc_r[29:0]; mul_b = 30'(thickness); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // The single compare/subtract serves the square root and both divisions.
  always_comb begin
    unique case (st_r)
      A_SQRT:        begin sub_a = s_r; sub_b = r_r + bit_r; end
      A_DIVX, A_DIVY: begin sub_a = 62'(num_r); sub_b = 62'(trial); end
      default:       begin sub_a = '0; sub_b = '0; end
    endcase
  end
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = !diff[62];
  assign q_new = {q_r[Q_BITS-2:0], ge};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      A_IDLE: begin
        if (start) begin
          st_nxt = ((mag_a == '0) && (mag_c == '0)) ? A_DONE : A_NORM;
        end
      end
      A_NORM: begin
        if ((mx[NW-1:30] == '0) && (mx[NW-1:29] != '0)) begin
          st_nxt = A_SQA;
        end
      end
      A_SQA:  st_nxt = A_SQC;
      A_SQC:  st_nxt = A_SQRT;
      A_SQRT: if (cnt_r == '0) st_nxt = A_MULX;
      A_MULX: st_nxt = A_DIVX;
      A_DIVX: if (cnt_r == '0) st_nxt = A_MULY;
      A_MULY: st_nxt = A_DIVY;
      A_DIVY: if (cnt_r == '0) st_nxt = A_DONE;
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      A_IDLE: begin
        na_r <= NW'(mag_a);
        nc_r <= NW'(mag_c);
        qx_r <= '0;
        qy_r <= '0;
      end
      A_NORM: begin
        if (mx[NW-1:30] != '0) begin
          na_r <= na_r >> 1;
          nc_r <= nc_r >> 1;
        end else if (mx[NW-1:29] == '0) begin
          na_r <= na_r << 1;
          nc_r <= nc_r << 1;
        end
      end
      A_SQA: s_r <= 62'(prod);
      A_SQC: begin
        s_r   <= s_r + 62'(prod);
        r_r   <= '0;
        bit_r <= 62'(1) << 60;
        cnt_r <= 5'd30;
      end
      A_SQRT: begin
        if (ge) begin
          s_r <= diff[61:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
      end
      A_MULX, A_MULY: begin
        num_r <= 44'(prod) + 44'(r_r[30:0]);
        q_r   <= '0;
        cnt_r <= 5'(Q_BITS - 1);
      end
      A_DIVX, A_DIVY: begin
        if (ge) num_r <= diff[43:0];
        q_r   <= q_new;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          if (st_r == A_DIVX) qx_r <= q_new;
          else qy_r <= q_new;
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = (st_r == A_DONE);
  assign rsp.qx   = qx_r;
  assign rsp.qy   = qy_r;

endmodule

// ===== rtl/core/polyline_stroke_quad_expander_top.sv =====
// Channel | Handshake                | Payload
// in      | in_valid / in_stall      | in_point_x, in_point_y, in_final_point
// out     | out_valid / out_stall    | out_item_kind .. out_run_end
// cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A point that opens a polyline, or any point while alpha is zero, only updates the path state.
// A point that ends a segment passes through a start state, then the shared arithmetic unit
// (10 to 29 normalize shifts, two squares, 31 square-root steps, two 12-step divides, or
// straight to done for a zero-length segment), then six output records;
// a closing segment repeats this once more.
// Reset is synchronous on rst_n; cfg_ready is always high.
// out_stall holds the current request in the output register and pauses the sequencer.
module polyline_stroke_quad_expander_top #(
  parameter int INDEX_BITS = 16,
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_point_x,
  input  logic signed [COORD_BITS-1:0]        in_point_y,
  input  logic                                in_final_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_item_kind,
  output logic signed [COORD_BITS-1:0]        out_vertex_x,
  output logic signed [COORD_BITS-1:0]        out_vertex_y,
  output logic [31:0]                         out_vertex_color,
  output logic [INDEX_BITS-1:0]               out_corner_a,
  output logic [INDEX_BITS-1:0]               out_corner_b,
  output logic [INDEX_BITS-1:0]               out_corner_c,
  output logic                                out_run_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plsq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data
);
  import plsq_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int MW = COORD_BITS + 1;

  top_state_t st_r, st_nxt;

  logic [THICK_BITS-1:0]   thick_r;
  logic [COLOR_BITS-1:0]   color_r;
  logic                    closed_r;
  logic signed [CW-1:0]    prevx_r, prevy_r, firstx_r, firsty_r;
  logic signed [CW-1:0]    p1x_r, p1y_r, p2x_r, p2y_r;
  logic                    have_prev_r, close_pend_r;
  logic [INDEX_BITS-1:0]   cnt_r;
  logic [2:0]              k_r;
  logic signed [OFS_BITS-1:0] ox_r, oy_r;

  logic                    in_acc, emit, alpha_ok, last_rec;
  logic signed [MW-1:0]    dx, dy;
  logic [MW-1:0]           mag_a, mag_c;
  arith_rsp_t              rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != T_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign alpha_ok  = (color_r[31:24] != 8'd0);

  assign dx    = MW'(p2x_r) - MW'(p1x_r);
  assign dy    = MW'(p2y_r) - MW'(p1y_r);
  assign mag_a = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign mag_c = dy[MW-1] ? MW'(-dy) : MW'(dy);

  plsq_arith #(.MAG_BITS(MW)) u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (st_r == T_START),
    .mag_a     (mag_a),
    .mag_c     (mag_c),
    .thickness (thick_r),
    .rsp       (rsp)
  );

  assign emit     = (st_r == T_EMIT) && (!out_valid || !out_stall);
  assign last_rec = (k_r == 3'd5);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:  if (in_acc && have_prev_r && alpha_ok) st_nxt = T_START;
      T_START: st_nxt = T_WAIT;
      T_WAIT:  if (rsp.done) st_nxt = T_EMIT;
      T_EMIT:  if (emit && last_rec) st_nxt = close_pend_r ? T_START : T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r  <= THICK_BITS'(16);
      color_r  <= '1;
      closed_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        REG_THICKNESS: thick_r  <= cfg_data[THICK_BITS-1:0];
        REG_COLOR:     color_r  <= cfg_data;
        REG_CLOSED:    closed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      close_pend_r <= 1'b0;
      cnt_r        <= '0;
      k_r          <= '0;
      prevx_r      <= '0;
      prevy_r      <= '0;
      firstx_r     <= '0;
      firsty_r     <= '0;
    end else begin
      if (in_acc) begin
        if (!have_prev_r) begin
          firstx_r <= in_point_x;
          firsty_r <= in_point_y;
        end
        p1x_r        <= prevx_r;
        p1y_r        <= prevy_r;
        p2x_r        <= in_point_x;
        p2y_r        <= in_point_y;
        prevx_r      <= in_point_x;
        prevy_r      <= in_point_y;
        have_prev_r  <= !in_final_point;
        close_pend_r <= in_final_point && closed_r;
        k_r          <= '0;
      end
      if (st_r == T_WAIT && rsp.done) begin
        ox_r <= dx[MW-1] ? -OFS_BITS'(rsp.qx) : OFS_BITS'(rsp.qx);
        oy_r <= dy[MW-1] ? -OFS_BITS'(rsp.qy) : OFS_BITS'(rsp.qy);
      end
      if (emit) begin
        if (last_rec) begin
          k_r   <= '0;
          cnt_r <= cnt_r + INDEX_BITS'(4);
          if (close_pend_r) begin
            // Closing segment runs from the final point back to the first one.
            close_pend_r <= 1'b0;
            p1x_r        <= p2x_r;
            p1y_r        <= p2y_r;
            p2x_r        <= firstx_r;
            p2y_r        <= firsty_r;
          end
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
    end
  end

  // Vertex position: corners 0 and 3 sit on p1, 1 and 2 on p2; 0 and 1 take +(dy,-dx).
  logic                 use_p1, plus_side;
  logic signed [MW-1:0] sum_x, sum_y;
  logic signed [CW-1:0] sat_x, sat_y;

  assign use_p1    = (k_r == 3'd0) || (k_r == 3'd3);
  assign plus_side = (k_r == 3'd0) || (k_r == 3'd1);
  assign sum_x = MW'(use_p1 ? p1x_r : p2x_r) + (plus_side ? MW'(oy_r) : -MW'(oy_r));
  assign sum_y = MW'(use_p1 ? p1y_r : p2y_r) + (plus_side ? -MW'(ox_r) : MW'(ox_r));

  always_comb begin
    sat_x = sum_x[CW-1:0];
    if (sum_x[MW-1] != sum_x[CW-1]) sat_x = {sum_x[MW-1], {(CW-1){!sum_x[MW-1]}}};
    sat_y = sum_y[CW-1:0];
    if (sum_y[MW-1] != sum_y[CW-1]) sat_y = {sum_y[MW-1], {(CW-1){!sum_y[MW-1]}}};
  end

  logic is_tri;
  assign is_tri = (k_r == 3'd4) || (k_r == 3'd5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_run_end <= last_rec && !close_pend_r;
      if (is_tri) begin
        out_item_kind    <= KIND_TRIANGLE;
        out_vertex_x     <= '0;
        out_vertex_y     <= '0;
        out_vertex_color <= '0;
        out_corner_a     <= cnt_r;
        out_corner_b     <= cnt_r + (last_rec ? INDEX_BITS'(3) : INDEX_BITS'(2));
        out_corner_c     <= cnt_r + (last_rec ? INDEX_BITS'(2) : INDEX_BITS'(1));
      end else begin
        out_item_kind    <= KIND_VERTEX;
        out_vertex_x     <= sat_x;
        out_vertex_y     <= sat_y;
        out_vertex_color <= color_r;
        out_corner_a     <= cnt_r + INDEX_BITS'(k_r);
        out_corner_b     <= '0;
        out_corner_c     <= '0;
      end
    end
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (st_r == T_WAIT)) else $error("arith done outside wait");
  a_end_on_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_end) |-> (out_item_kind == KIND_TRIANGLE))
    else $error("run end on a vertex record");
  a_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item_kind == KIND_VERTEX) |-> (out_corner_b == '0 && out_corner_c == '0))
    else $error("vertex record with triangle corners");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plsq_pkg::*;

  localparam int CB = 20;
  localparam int IB = 16;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 fin;
    int                   gap;
  } point_req_t;

  typedef struct packed {
    logic          kind;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [31:0]   color;
    logic [IB-1:0] a;
    logic [IB-1:0] b;
    logic [IB-1:0] c;
    logic          run_end;
  } stroke_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_point_x = '0;
  logic signed [CB-1:0] in_point_y = '0;
  logic in_final_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_item_kind;
  logic signed [CB-1:0] out_vertex_x;
  logic signed [CB-1:0] out_vertex_y;
  logic [31:0] out_vertex_color;
  logic [IB-1:0] out_corner_a;
  logic [IB-1:0] out_corner_b;
  logic [IB-1:0] out_corner_c;
  logic out_run_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  polyline_stroke_quad_expander_top #(.INDEX_BITS(IB), .COORD_BITS(CB)) uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the block's registers and path state.
  logic [11:0]   stroke_thick;
  logic [31:0]   stroke_color;
  logic          closed_mode;
  longint        prev_x, prev_y, first_x, first_y;
  logic          have_prev;
  logic [IB-1:0] vertex_count;

  point_req_t  point_q[$];
  stroke_rec_t expected_recs[$];
  int errors = 0;
  int points_taken = 0;
  int recs_checked = 0;
  int settings_used = 1;
  int gap_left = 0;
  int stall_left = 0;
  int hold_cnt = 0;
  int hold_go = 0;
  int hold_seen = 0;
  logic rx_calm = 1'b0;

  function automatic longint unsigned isqrt(input longint unsigned s);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [CB-1:0] clamp_coord(input longint v);
    if (v > 524287) return 20'h7FFFF;
    if (v < -524288) return 20'h80000;
    return v[CB-1:0];
  endfunction

  // Half-thickness offset along the unit direction, rounded half up.
  function automatic void half_width(input longint dx, input longint dy,
                                     output longint ox, output longint oy);
    longint unsigned a, c, m, len, qx, qy;
    ox = 0;
    oy = 0;
    a = (dx < 0) ? -dx : dx;
    c = (dy < 0) ? -dy : dy;
    if (a == 0 && c == 0) return;
    m = (a > c) ? a : c;
    while (m >= (64'd1 << 30)) begin a >>= 1; c >>= 1; m >>= 1; end
    while (m < (64'd1 << 29)) begin a <<= 1; c <<= 1; m <<= 1; end
    len = isqrt(a * a + c * c);
    qx = (longint'(stroke_thick) * a + len) / (2 * len);
    qy = (longint'(stroke_thick) * c + len) / (2 * len);
    ox = (dx < 0) ? -longint'(qx) : longint'(qx);
    oy = (dy < 0) ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic void push_vertex(input longint x, input longint y,
                                      input logic [IB-1:0] idx);
    stroke_rec_t r;
    r = '0;
    r.kind = KIND_VERTEX;
    r.x = clamp_coord(x);
    r.y = clamp_coord(y);
    r.color = stroke_color;
    r.a = idx;
    expected_recs = {expected_recs, r};
  endfunction

  function automatic void push_triangle(input logic [IB-1:0] a, input logic [IB-1:0] b,
                                        input logic [IB-1:0] c);
    stroke_rec_t r;
    r = '0;
    r.kind = KIND_TRIANGLE;
    r.a = a;
    r.b = b;
    r.c = c;
    expected_recs = {expected_recs, r};
  endfunction

  function automatic void quad_for_segment(input longint x1, input longint y1,
                                           input longint x2, input longint y2);
    longint ox, oy;
    logic [IB-1:0] b;
    b = vertex_count;
    half_width(x2 - x1, y2 - y1, ox, oy);
    push_vertex(x1 + oy, y1 - ox, b);
    push_vertex(x2 + oy, y2 - ox, IB'(b + 1));
    push_vertex(x2 - oy, y2 + ox, IB'(b + 2));
    push_vertex(x1 - oy, y1 + ox, IB'(b + 3));
    push_triangle(b, IB'(b + 2), IB'(b + 1));
    push_triangle(b, IB'(b + 3), IB'(b + 2));
    vertex_count = IB'(b + 4);
  endfunction

  function automatic void stroke_point(input logic signed [CB-1:0] x,
                                       input logic signed [CB-1:0] y, input logic fin);
    int n0;
    logic alpha_on;
    n0 = expected_recs.size();
    alpha_on = (stroke_color[31:24] != 0);
    if (!have_prev) begin
      first_x = x;
      first_y = y;
    end else begin
      if (alpha_on) quad_for_segment(prev_x, prev_y, x, y);
      if (fin && closed_mode && alpha_on) quad_for_segment(x, y, first_x, first_y);
    end
    prev_x = x;
    prev_y = y;
    have_prev = !fin;
    if (expected_recs.size() > n0) expected_recs[expected_recs.size() - 1].run_end = 1'b1;
  endfunction

  // Point driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        stroke_point(in_point_x, in_point_y, in_final_point);
        points_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (point_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (point_q[0].gap > 0) begin
          point_q[0].gap--;
          in_valid <= 1'b0;
        end else begin
          in_point_x <= point_q[0].x;
          in_point_y <= point_q[0].y;
          in_final_point <= point_q[0].fin;
          in_valid <= 1'b1;
          void'(point_q.pop_front());
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_cnt <= HOLD_CYCLES;
      hold_seen <= hold_go;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    stroke_rec_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_item_kind, out_vertex_x, out_vertex_y, out_vertex_color,
               out_corner_a, out_corner_b, out_corner_c, out_run_end};
        recs_checked++;
        if (expected_recs.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected record %p", got);
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("record mismatch: expected %p, got %p", want, got);
          end
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0) || (hold_cnt != 0);
    end
  end

  int tx_gap_max = 19;

  task automatic add_point(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                           input logic fin);
    point_req_t p;
    p.x = x;
    p.y = y;
    p.fin = fin;
    p.gap = $urandom_range(0, tx_gap_max);
    point_q = {point_q, p};
  endtask

  function automatic logic signed [CB-1:0] pick_coord(input logic signed [CB-1:0] base);
    case ($urandom_range(0, 7))
      0: return CB'($urandom);
      1: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
      2: return base;
      default: return base + CB'($urandom_range(0, 4095)) - 20'sd2048;
    endcase
  endfunction

  task automatic random_paths(input int npts);
    int left, len;
    logic signed [CB-1:0] bx, by;
    left = npts;
    while (left > 0) begin
      len = $urandom_range(1, 6);
      bx = CB'($urandom);
      by = CB'($urandom);
      for (int i = 0; i < len; i++) begin
        bx = pick_coord(bx);
        by = pick_coord(by);
        // About one path in ten is left open and runs on into the next one, maybe past a register change.
        add_point(bx, by, (i == len - 1) && ($urandom_range(0, 9) != 0));
      end
      left -= len;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THICKNESS: stroke_thick = val[11:0];
      REG_COLOR:     stroke_color = val;
      REG_CLOSED:    closed_mode = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    while (point_q.size() != 0 || in_valid || expected_recs.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [11:0] th, input logic [31:0] col,
                               input logic cl);
    drain();
    write_reg(REG_THICKNESS, 32'(th));
    write_reg(REG_COLOR, col);
    write_reg(REG_CLOSED, 32'(cl));
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    stroke_thick = 12'd16;
    stroke_color = 32'hFFFFFFFF;
    closed_mode = 1'b0;
    prev_x = 0;
    prev_y = 0;
    first_x = 0;
    first_y = 0;
    have_prev = 1'b0;
    vertex_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lone point, zero-length segment, saturating diagonal, axis-aligned and diagonal segments.
    add_point(0, 0, 1);
    add_point(0, 0, 0);
    add_point(0, 0, 1);
    add_point(20'sh80000, 20'sh80000, 0);
    add_point(20'sh7FFFF, 20'sh7FFFF, 1);
    add_point(100, 0, 0);
    add_point(-100, 0, 0);
    add_point(-100, 300, 0);
    add_point(-100, -300, 1);
    add_point(20'sh7FFFF, 0, 0);
    add_point(20'sh7FFFF, 20'sh80000, 1);
    add_point(20'sh55555, 20'shAAAAA, 0);
    add_point(20'shAAAAA, 20'sh55555, 1);

    // Closed paths at maximum thickness; the write beyond the list must be ignored.
    apply_setting(12'hFFF, 32'h80123456, 1'b1);
    write_reg(CFG_IDX_BITS'(REG_CLOSED + 2'd1), 32'hFFFFFFFF);
    @(negedge clk);
    add_point(0, 0, 0);
    add_point(160, 0, 1);
    add_point(0, 0, 0);
    add_point(300, 50, 0);
    add_point(-40, 700, 1);
    add_point(5, 5, 0);
    add_point(5, 5, 1);
    random_paths(50);

    // Alpha zero: points are tracked but nothing comes out.
    apply_setting(12'd40, 32'h00FFFFFF, 1'b1);
    random_paths(15);
    add_point(1000, -2000, 0);

    // Zero thickness, open paths; the open path above is finished here.
    apply_setting(12'd0, 32'h7F00FF00, 1'b0);
    add_point(-3000, 1234, 1);
    random_paths(50);

    // Long receiver hold while the sender keeps pushing.
    apply_setting(12'($urandom_range(1, 4094)), $urandom | 32'h01000000, 1'b1);
    tx_gap_max = 0;
    hold_go <= hold_go + 1;
    random_paths(30);
    tx_gap_max = 19;
    random_paths(30);

    // Back-to-back stretch with no idling on either side.
    apply_setting(12'($urandom_range(0, 4095)), $urandom | 32'h01000000,
                  1'($urandom_range(0, 1)));
    rx_calm <= 1'b1;
    tx_gap_max = 0;
    random_paths(25);
    drain();
    rx_calm <= 1'b0;
    tx_gap_max = 19;
    apply_setting(12'd16, 32'hFFFFFFFF, 1'b0);
    random_paths(40);
    drain();

    errors += expected_recs.size();
    $display("Fed %0d points through %0d register settings, checked %0d output records.",
             points_taken, settings_used, recs_checked);
    $display("Open and closed paths, alpha zero, zero-length and saturating segments.");
    if (errors == 0) begin
      $display("polyline_stroke_quad_expander_top: match");
    end else begin
      $display("polyline_stroke_quad_expander_top: mismatch");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("polyline_stroke_quad_expander_top: mismatch");
    $finish;
  end

endmodule
